/* rtl/core/tld_pkg.sv */
// tld_pkg: types and constants for the terminal line discipline
// no dependencies
`default_nettype none
package tld_pkg;
  localparam logic [1:0] ACT_RX    = 2'd0;
  localparam logic [1:0] ACT_TXRDY = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [2:0] RK_EMPTY    = 3'd0;
  localparam logic [2:0] RK_APPEND   = 3'd1;
  localparam logic [2:0] RK_LINEDONE = 3'd2;
  localparam logic [2:0] RK_ERASED   = 3'd3;
  localparam logic [2:0] RK_IGNORED  = 3'd4;
  localparam logic [2:0] RK_CRDONE   = 3'd5;

  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_QM  = 8'h3F;
  localparam logic [7:0] CH_CIRC = 8'h5E;
  localparam logic [7:0] CH_MASK = 8'h7F;
  localparam logic [7:0] CH_CTRL = 8'h40;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] port;
    logic [7:0] data_byte;
    logic       line_error;
  } req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       accepted;
    logic [6:0] read_char;
    logic [2:0] read_kind;
    logic [6:0] line_length;
  } rsp_t;
endpackage
`default_nettype wire

/* rtl/core/tld_if.sv */
// tld_if: valid/ready channel carrying a payload of type T
// depends on nothing; payload type given per instance
`default_nettype none
interface tld_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/tld_ram.sv */
// tld_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
`default_nettype none
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 96
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/core/terminal_line_discipline.sv */
// terminal_line_discipline: top level, event sequencer over the queue memories
// depends on tld_pkg, tld_if, tld_ram
`default_nettype none
// Terminal line discipline for PORTS serial ports. Each port has an input,
// an output and an echo queue of QUEUE_DEPTH bytes held in three rams; queue
// pointers, transmitter-idle flags and line counts live in flip-flops. One
// request is taken at a time. A port out of range or a host read of an empty
// queue goes straight to posting the result. Any other host read first takes
// the ram's registered read of the input character and then posts the result,
// save an erase, which goes on like the other requests: these push their
// bytes one at a time (up to three), choose what to send, take the registered
// read of the echo or output ram when a byte is popped, and post the result.
// The result sits in an output register; the next request is taken the cycle
// after it has been handed over. Queue contents need no clearing pass after
// reset since every entry is written before read.
module terminal_line_discipline #(
  parameter int PORTS       = 3,
  parameter int QUEUE_DEPTH = 32,
  parameter int LINE_MAX    = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  tld_if.sink       req,
  tld_if.source     rsp
);
  localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = QW + 1;
  localparam int DEPTH = PORTS * QUEUE_DEPTH;
  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(LINE_MAX + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PUSH = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_RDIN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // queue selects
  localparam logic [1:0] Q_IN   = 2'd0;
  localparam logic [1:0] Q_OUT  = 2'd1;
  localparam logic [1:0] Q_ECHO = 2'd2;

  logic [2:0] state;
  logic       echo_enable;

  // per-port queue pointers, indexed by queue select
  logic [QW-1:0] head [3][PORTS];
  logic [CW-1:0] cnt  [3][PORTS];
  logic [PORTS-1:0] tx_idle;
  logic [LW-1:0] line_cnt [PORTS];

  // pending pushes: up to three bytes, queue select per byte
  logic [7:0] pb [3];
  logic [1:0] pq [3];
  logic [1:0] npend;
  logic       kick;
  logic       pop_q_out;       // which queue the transmit pop came from
  tld_pkg::req_t r;
  tld_pkg::rsp_t res;
  logic          res_valid;

  logic [PW-1:0] p;
  assign p = r.port[PW-1:0];

  // input ram is read while the request is being taken
  logic [PW-1:0] rp;
  assign rp = (state == S_IDLE) ? req.data.port[PW-1:0] : p;

  // ram ports
  logic            in_we, out_we, ec_we;
  logic [AW-1:0]   waddr, in_ra, out_ra, ec_ra;
  logic [7:0]      wdata;
  logic [6:0]      in_rd;
  logic [7:0]      out_rd, ec_rd;

  function automatic logic [AW-1:0] addr(input logic [PW-1:0] pp, input logic [QW-1:0] s);
    logic [AW+PW-1:0] a;
    a = AW'(pp) * AW'(QUEUE_DEPTH) + AW'(s);
    return a[AW-1:0];
  endfunction

  tld_ram #(.WIDTH(7), .DEPTH(DEPTH)) u_in (.clk(clk), .we(in_we), .waddr(waddr),
    .wdata(wdata[6:0]), .raddr(in_ra), .rdata(in_rd));
  tld_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_out (.clk(clk), .we(out_we), .waddr(waddr),
    .wdata(wdata), .raddr(out_ra), .rdata(out_rd));
  tld_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_echo (.clk(clk), .we(ec_we), .waddr(waddr),
    .wdata(wdata), .raddr(ec_ra), .rdata(ec_rd));

  assign in_ra  = addr(rp, head[Q_IN][rp]);
  assign out_ra = addr(p, head[Q_OUT][p]);
  assign ec_ra  = addr(p, head[Q_ECHO][p]);

  // current push target
  logic [1:0]    cq;
  logic [QW+1:0] slot_sum;
  logic [QW-1:0] slot;
  logic          cfull;
  logic          pushing;
  assign cq = pq[0];
  assign slot_sum = (QW+2)'(head[cq][p]) + (QW+2)'(cnt[cq][p]);
  // mod depth: sum is below twice the depth
  assign slot = (slot_sum >= (QW+2)'(QUEUE_DEPTH)) ?
    QW'(slot_sum - (QW+2)'(QUEUE_DEPTH)) : QW'(slot_sum);
  assign cfull = (cnt[cq][p] == CW'(QUEUE_DEPTH));
  assign pushing = (state == S_PUSH) && (npend != '0) && !cfull;
  assign waddr = addr(p, slot);
  assign wdata = pb[0];
  assign in_we  = pushing && (cq == Q_IN);
  assign out_we = pushing && (cq == Q_OUT);
  assign ec_we  = pushing && (cq == Q_ECHO);

  assign req.ready = (state == S_IDLE) && !res_valid;
  assign rsp.valid = res_valid;
  assign rsp.data  = res;

  // decode of a received character
  logic [6:0] rch;
  assign rch = req.data.line_error ? tld_pkg::CH_QM[6:0] :
               req.data.data_byte[6:0];

  function automatic logic [QW-1:0] inc(input logic [QW-1:0] h);
    return (h == QW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  logic [LW-1:0] lc_inc;
  assign lc_inc = line_cnt[p] + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      echo_enable <= 1'b1;
      res_valid <= 1'b0;
      tx_idle <= '1;
      npend <= '0;
      kick <= 1'b0;
      for (int q = 0; q < 3; q++)
        for (int i = 0; i < PORTS; i++) begin
          head[q][i] <= '0;
          cnt[q][i] <= '0;
        end
      for (int i = 0; i < PORTS; i++) line_cnt[i] <= '0;
    end else begin
      if (cfg_we) echo_enable <= cfg_wdata;
      if (rsp.valid && rsp.ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          tld_pkg::rsp_t rn;
          logic [7:0]    eb [3];
          logic [1:0]    eq [3];
          logic [1:0]    en;
          logic          kn;
          logic [2:0]    st;
          logic [PW-1:0] ip;
          if (req.valid && req.ready) begin
            rn = '0;
            en = '0;
            kn = 1'b0;
            st = S_PUSH;
            ip = req.data.port[PW-1:0];
            for (int k = 0; k < 3; k++) begin eb[k] = '0; eq[k] = Q_ECHO; end
            if (32'(req.data.port) >= PORTS) begin
              st = S_DONE;
            end else begin
              case (req.data.action)
                tld_pkg::ACT_RX: begin
                  kn = 1'b1;
                  if (cnt[Q_IN][ip] == CW'(QUEUE_DEPTH)) begin
                    eb[0] = tld_pkg::CH_BEL; en = 2'd1;
                  end else begin
                    rn.accepted = 1'b1;
                    // optional input push then echo bytes
                    if (rch != 7'd0) begin
                      eb[0] = {1'b0, rch}; eq[0] = Q_IN; en = 2'd1;
                    end
                    if (echo_enable) begin
                      if ((rch >= 7'h20 && rch <= 7'h7E) || (rch >= 7'h09 && rch <= 7'h0D)) begin
                        eb[en] = {1'b0, rch}; en = en + 1'b1;
                        if ({1'b0, rch} == tld_pkg::CH_CR) begin
                          eb[en] = tld_pkg::CH_LF; en = en + 1'b1;
                        end
                      end else if ({1'b0, rch} != tld_pkg::CH_BS) begin
                        eb[en] = tld_pkg::CH_CIRC; en = en + 1'b1;
                        eb[en] = {1'b0, rch} ^ tld_pkg::CH_CTRL; en = en + 1'b1;
                      end
                    end
                  end
                end
                tld_pkg::ACT_TXRDY: begin
                  kn = 1'b1;
                  tx_idle[ip] <= 1'b1;
                end
                tld_pkg::ACT_WRITE: begin
                  if (CW'(QUEUE_DEPTH) - cnt[Q_OUT][ip] >=
                      ((req.data.data_byte == tld_pkg::CH_LF) ? CW'(2) : CW'(1))) begin
                    rn.accepted = 1'b1;
                    kn = 1'b1;
                    eq[0] = Q_OUT; eq[1] = Q_OUT;
                    if (req.data.data_byte == tld_pkg::CH_LF) begin
                      eb[0] = tld_pkg::CH_CR; eb[1] = req.data.data_byte; en = 2'd2;
                    end else begin
                      eb[0] = req.data.data_byte; en = 2'd1;
                    end
                  end
                end
                default: begin
                  if (cnt[Q_IN][ip] != '0) st = S_RDIN;
                  else begin
                    rn.line_length = 7'(line_cnt[ip]);
                    st = S_DONE;
                  end
                end
              endcase
            end
            r <= req.data;
            res <= rn;
            pb <= eb;
            pq <= eq;
            npend <= en;
            kick <= kn;
            state <= st;
          end
        end
        S_PUSH: begin
          if (npend != '0) begin
            if (!cfull) cnt[cq][p] <= cnt[cq][p] + 1'b1;
            pb[0] <= pb[1]; pb[1] <= pb[2];
            pq[0] <= pq[1]; pq[1] <= pq[2];
            npend <= npend - 1'b1;
          end else if (kick && tx_idle[p]) begin
            if (cnt[Q_ECHO][p] != '0) begin
              tx_idle[p] <= 1'b0;
              pop_q_out <= 1'b0;
              head[Q_ECHO][p] <= inc(head[Q_ECHO][p]);
              cnt[Q_ECHO][p] <= cnt[Q_ECHO][p] - 1'b1;
              state <= S_POP;
            end else if (cnt[Q_OUT][p] != '0) begin
              tx_idle[p] <= 1'b0;
              pop_q_out <= 1'b1;
              head[Q_OUT][p] <= inc(head[Q_OUT][p]);
              cnt[Q_OUT][p] <= cnt[Q_OUT][p] - 1'b1;
              state <= S_POP;
            end else begin
              // nothing to send, transmitter stays idle
              res.line_length <= 7'(line_cnt[p]);
              state <= S_DONE;
            end
          end else begin
            res.line_length <= 7'(line_cnt[p]);
            state <= S_DONE;
          end
        end
        S_POP: begin
          // ram read of the old head was registered last cycle
          res.tx_valid <= 1'b1;
          res.tx_byte <= pop_q_out ? out_rd : ec_rd;
          res.line_length <= 7'(line_cnt[p]);
          state <= S_DONE;
        end
        S_RDIN: begin
          head[Q_IN][p] <= inc(head[Q_IN][p]);
          cnt[Q_IN][p] <= cnt[Q_IN][p] - 1'b1;
          if ({1'b0, in_rd} == tld_pkg::CH_BS) begin
            if (line_cnt[p] != '0) begin
              line_cnt[p] <= line_cnt[p] - 1'b1;
              res.read_kind <= tld_pkg::RK_ERASED;
              pb[0] <= tld_pkg::CH_BS; pb[1] <= tld_pkg::CH_SP; pb[2] <= tld_pkg::CH_BS;
              pq[0] <= Q_ECHO; pq[1] <= Q_ECHO; pq[2] <= Q_ECHO;
              npend <= 2'd3; kick <= 1'b1;
              state <= S_PUSH;
            end else begin
              res.read_kind <= tld_pkg::RK_IGNORED;
              res.line_length <= 7'(line_cnt[p]);
              state <= S_DONE;
            end
          end else if ({1'b0, in_rd} == tld_pkg::CH_CR) begin
            res.read_kind <= tld_pkg::RK_CRDONE;
            res.line_length <= 7'(line_cnt[p]);
            line_cnt[p] <= '0;
            state <= S_DONE;
          end else begin
            res.read_char <= in_rd;
            res.line_length <= 7'(lc_inc);
            state <= S_DONE;
            if ({1'b0, in_rd} == tld_pkg::CH_ESC || 32'(lc_inc) >= LINE_MAX) begin
              res.read_kind <= tld_pkg::RK_LINEDONE;
              line_cnt[p] <= '0;
            end else begin
              res.read_kind <= tld_pkg::RK_APPEND;
              line_cnt[p] <= lc_inc;
            end
          end
        end
        S_DONE: begin
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result never coexists with a new request being taken
  assert property (@(posedge clk) disable iff (rst) res_valid |-> !req.ready)
    else $error("request taken while result pending");
  // at most one queue written per cycle
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({in_we, out_we, ec_we}))
    else $error("more than one queue written");
  // a result follows in the cycle after the done state
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> res_valid)
    else $error("result lost");
endmodule
`default_nettype wire
